// File: src/eight_bit_teaching_cpu_step_top_macros.svh
// Assertion macros for the teaching CPU step block.
// Needs i_clk and i_rst_n in the scope that uses them.
`ifndef EIGHT_BIT_TEACHING_CPU_STEP_TOP_MACROS_SVH
`define EIGHT_BIT_TEACHING_CPU_STEP_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define EBTC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define EBTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/ebtc_pkg.sv
// Types, codes and sizes for the teaching CPU step block.
// No dependencies.
`default_nettype none

package ebtc_pkg;

    localparam int MEM_BYTES = 256;
    localparam int REG_COUNT = 16;

    typedef struct packed {
        logic       op;
        logic [7:0] address;
        logic [7:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  program_counter_out;
        logic [15:0] instruction_word;
    } t_out_item;

    // item kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_EXECUTED = 2'd0;
    localparam logic [1:0] ST_HALTED   = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;
    localparam logic [1:0] ST_WRITTEN  = 2'd3;

    // opcodes
    localparam logic [3:0] OPC_LOAD  = 4'h1;
    localparam logic [3:0] OPC_LDI   = 4'h2;
    localparam logic [3:0] OPC_STORE = 4'h3;
    localparam logic [3:0] OPC_MOVE  = 4'h4;
    localparam logic [3:0] OPC_ADD   = 4'h5;
    localparam logic [3:0] OPC_JUMP  = 4'hB;
    localparam logic [3:0] OPC_HALT  = 4'hC;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH1,
        S_FETCH2,
        S_EXEC,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: src/eight_bit_teaching_cpu_step_top.sv
// Teaching CPU step block: a write item or a halted step goes from idle straight to
// the hand-off state; a step item passes through fetch high byte, fetch low byte,
// execute and hand off. A new item is taken only in idle; one memory port serves
// both fetch reads and the data access. Reset clears PC, halt flag and register
// valid bits; memory holds no reset value. Uses ebtc_pkg and the macro header.
`default_nettype none
`include "eight_bit_teaching_cpu_step_top_macros.svh"

module eight_bit_teaching_cpu_step_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire ebtc_pkg::t_in_item i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output ebtc_pkg::t_out_item    o_out
);

    // state
    ebtc_pkg::t_state    r_state, n_state;
    logic [7:0]          r_pc, n_pc;
    logic                r_halted, n_halted;
    logic [15:0]         r_instr, n_instr;
    logic [1:0]          r_status, n_status;
    logic                r_out_valid, n_out_valid;
    ebtc_pkg::t_out_item r_out, n_out;

    // memory port
    logic [7:0] mem_q [ebtc_pkg::MEM_BYTES];
    logic [7:0] r_mem_rdata;
    logic       mem_we;
    logic [7:0] mem_addr;
    logic [7:0] mem_wdata;

    // register file, two registered read ports
    logic [7:0]                    rf_q [ebtc_pkg::REG_COUNT];
    logic [ebtc_pkg::REG_COUNT-1:0] r_rf_valid;
    logic [7:0] r_rf_rd_a, r_rf_rd_b;
    logic       r_rf_vld_a, r_rf_vld_b;
    logic       rf_we;
    logic [3:0] rf_waddr, rf_raddr_a, rf_raddr_b;
    logic [7:0] rf_wdata;
    logic [7:0] rf_a_val, rf_b_val;

    // shared adder
    logic [7:0] alu_a, alu_b, alu_sum;

    logic       in_accept;
    logic [3:0] fetch_opc, exec_opc;

    assign alu_sum    = alu_a + alu_b;
    assign o_in_ready = (r_state == ebtc_pkg::S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // never-written registers read as zero
    assign rf_a_val  = r_rf_vld_a ? r_rf_rd_a : 8'd0;
    assign rf_b_val  = r_rf_vld_b ? r_rf_rd_b : 8'd0;
    assign fetch_opc = r_instr[15:12];
    assign exec_opc  = r_instr[15:12];

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_halted    = r_halted;
        n_instr     = r_instr;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_addr    = r_pc;
        mem_wdata   = i_in.write_data;
        rf_we       = 1'b0;
        rf_waddr    = r_instr[11:8];
        rf_wdata    = r_instr[7:0];
        rf_raddr_a  = r_instr[11:8];
        rf_raddr_b  = 4'd0;
        alu_a       = r_pc;
        alu_b       = 8'd1;

        // drop the result once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ebtc_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_in.op == ebtc_pkg::OP_WRITE) begin
                        mem_we   = 1'b1;
                        mem_addr = i_in.address;
                        n_status = ebtc_pkg::ST_WRITTEN;
                        n_instr  = 16'd0;
                        n_state  = ebtc_pkg::S_DONE;
                    end else if (r_halted) begin
                        n_status = ebtc_pkg::ST_HALTED;
                        n_instr  = 16'd0;
                        n_state  = ebtc_pkg::S_DONE;
                    end else begin
                        mem_addr = r_pc;
                        n_state  = ebtc_pkg::S_FETCH1;
                    end
                end
            end
            ebtc_pkg::S_FETCH1: begin
                // high byte arrives; read PC+1
                alu_a         = r_pc;
                alu_b         = 8'd1;
                mem_addr      = alu_sum;
                n_instr[15:8] = r_mem_rdata;
                n_state       = ebtc_pkg::S_FETCH2;
            end
            ebtc_pkg::S_FETCH2: begin
                // low byte arrives; advance PC, start operand reads
                alu_a        = r_pc;
                alu_b        = 8'd2;
                n_pc         = alu_sum;
                n_instr[7:0] = r_mem_rdata;
                mem_addr     = r_mem_rdata;
                case (fetch_opc)
                    ebtc_pkg::OPC_MOVE: begin
                        rf_raddr_a = r_mem_rdata[7:4];
                    end
                    ebtc_pkg::OPC_ADD: begin
                        rf_raddr_a = r_mem_rdata[7:4];
                        rf_raddr_b = r_mem_rdata[3:0];
                    end
                    default: begin
                        rf_raddr_a = r_instr[11:8];
                        rf_raddr_b = 4'd0;
                    end
                endcase
                n_state = ebtc_pkg::S_EXEC;
            end
            ebtc_pkg::S_EXEC: begin
                n_status = ebtc_pkg::ST_EXECUTED;
                n_state  = ebtc_pkg::S_DONE;
                case (exec_opc)
                    ebtc_pkg::OPC_LOAD: begin
                        rf_we    = 1'b1;
                        rf_wdata = r_mem_rdata;
                    end
                    ebtc_pkg::OPC_LDI: begin
                        rf_we    = 1'b1;
                        rf_wdata = r_instr[7:0];
                    end
                    ebtc_pkg::OPC_STORE: begin
                        mem_we    = 1'b1;
                        mem_addr  = r_instr[7:0];
                        mem_wdata = rf_a_val;
                    end
                    ebtc_pkg::OPC_MOVE: begin
                        rf_we    = 1'b1;
                        rf_waddr = r_instr[3:0];
                        rf_wdata = rf_a_val;
                    end
                    ebtc_pkg::OPC_ADD: begin
                        alu_a    = rf_a_val;
                        alu_b    = rf_b_val;
                        rf_we    = 1'b1;
                        rf_wdata = alu_sum;
                    end
                    ebtc_pkg::OPC_JUMP: begin
                        if (rf_a_val == rf_b_val) begin
                            n_pc = r_instr[7:0];
                        end
                    end
                    ebtc_pkg::OPC_HALT: begin
                        n_halted = 1'b1;
                        n_status = ebtc_pkg::ST_HALTED;
                    end
                    default: begin
                        n_status = ebtc_pkg::ST_INVALID;
                    end
                endcase
            end
            ebtc_pkg::S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid               = 1'b1;
                    n_out.status              = r_status;
                    n_out.program_counter_out = r_pc;
                    n_out.instruction_word    = r_instr;
                    n_state                   = ebtc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ebtc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ebtc_pkg::S_IDLE;
            r_pc        <= 8'd0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
            r_rf_valid  <= '0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
            if (rf_we) begin
                r_rf_valid[rf_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_instr    <= n_instr;
        r_status   <= n_status;
        r_out      <= n_out;
        r_rf_vld_a <= r_rf_valid[rf_raddr_a];
        r_rf_vld_b <= r_rf_valid[rf_raddr_b];
    end

    // main memory, one port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_q[mem_addr] <= mem_wdata;
        end
        r_mem_rdata <= mem_q[mem_addr];
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            rf_q[rf_waddr] <= rf_wdata;
        end
        r_rf_rd_a <= rf_q[rf_raddr_a];
        r_rf_rd_b <= rf_q[rf_raddr_b];
    end

    `EBTC_ASSERT_NEXT(a_halt_sticks, r_halted, r_halted, "halt flag cleared without reset")
    `EBTC_ASSERT_NEXT(a_halted_step,
        in_accept && i_in.op == ebtc_pkg::OP_STEP && r_halted,
        r_state == ebtc_pkg::S_DONE && r_status == ebtc_pkg::ST_HALTED,
        "halted step did not report halt")
    `EBTC_ASSERT_NEXT(a_write_item,
        in_accept && i_in.op == ebtc_pkg::OP_WRITE,
        r_state == ebtc_pkg::S_DONE && r_status == ebtc_pkg::ST_WRITTEN,
        "write item not reported")
    `EBTC_ASSERT_SAME(a_mem_we_state, mem_we,
        r_state == ebtc_pkg::S_IDLE || r_state == ebtc_pkg::S_EXEC,
        "memory write outside idle or execute")
    `EBTC_ASSERT_SAME(a_rf_we_state, rf_we, r_state == ebtc_pkg::S_EXEC && !r_halted,
        "register write outside execute")

endmodule

`default_nettype wire
